/* hw/rtl/boxavg_pkg.sv */
package boxavg_pkg;

   localparam int DIM_W      = 11;
   localparam int OUT_COLS_W = 9;
   localparam int SAMPLE_W   = 16;
   localparam int COL_W      = 8;
   localparam int ROW_W      = 10;
   localparam int AREA_W     = 2 * DIM_W;
   localparam int SUM_W      = AREA_W + SAMPLE_W;
   localparam int QUOT_W     = 16;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = DIM_W;

   localparam logic [CSR_IDX_W-1:0] REG_IN_WIDTH   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_IN_HEIGHT  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_OUT_WIDTH  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_OUT_HEIGHT = 3'd3;

   localparam logic [DIM_W-1:0]      RST_IN_WIDTH   = 11'd1024;
   localparam logic [DIM_W-1:0]      RST_IN_HEIGHT  = 11'd1024;
   localparam logic [OUT_COLS_W-1:0] RST_OUT_WIDTH  = 9'd256;
   localparam logic [DIM_W-1:0]      RST_OUT_HEIGHT = 11'd256;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample;
   } req_word_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] average;
      logic [COL_W-1:0]           out_col;
      logic [ROW_W-1:0]           out_row;
      logic                       map_done;
   } rsp_word_type;

   typedef struct packed {
      logic [CSR_IDX_W-1:0]  index;
      logic [CSR_DATA_W-1:0] data;
   } csr_word_type;

   typedef struct packed {
      logic signed [SUM_W-1:0] sum;
      logic [COL_W-1:0]        col;
      logic [ROW_W-1:0]        row;
      logic                    done;
   } block_word_type;

   typedef struct packed {
      logic           valid;
      block_word_type word;
   } queue_head_type;

   typedef enum logic [1:0] {
      F_LOAD,
      F_RUN,
      F_ACTIVE
   } front_state_type;

   typedef enum logic [1:0] {
      B_IDLE,
      B_RUN,
      B_FINISH
   } back_state_type;

endpackage

/* hw/rtl/boxavg_stream_if.sv */
interface boxavg_stream_if #(
   parameter type word_type = logic
);
   logic     valid;
   logic     ready;
   word_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

/* hw/rtl/boxavg_front.sv */
module boxavg_front #(
   parameter int MAX_IN_WIDTH  = 1024,
   parameter int MAX_IN_HEIGHT = 1024,
   parameter int MAX_OUT_COLS  = 256
) (
   input  logic                          clock,
   input  logic                          reset,
   boxavg_stream_if.sink                 csr_chan,
   boxavg_stream_if.sink                 req_chan,
   input  logic                          queue_room,
   output logic                          push_valid,
   output boxavg_pkg::block_word_type    push_word,
   output logic [boxavg_pkg::AREA_W-1:0] area
);
   import boxavg_pkg::*;

   localparam int DIM_MAX   = (1 << DIM_W) - 1;
   localparam int COLS_MAX  = (1 << OUT_COLS_W) - 1;
   localparam int IW_CAP    = (MAX_IN_WIDTH < DIM_MAX) ? MAX_IN_WIDTH : DIM_MAX;
   localparam int IH_CAP    = (MAX_IN_HEIGHT < DIM_MAX) ? MAX_IN_HEIGHT : DIM_MAX;
   localparam int OW_CAP    = (MAX_OUT_COLS < COLS_MAX) ? MAX_OUT_COLS : COLS_MAX;
   localparam int MEM_DEPTH = OW_CAP;
   localparam int IDX_W     = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
   localparam int STEP_W    = $clog2(DIM_W);

   localparam logic [DIM_W-1:0]      IW_CAP_V  = DIM_W'(IW_CAP);
   localparam logic [DIM_W-1:0]      IH_CAP_V  = DIM_W'(IH_CAP);
   localparam logic [OUT_COLS_W-1:0] OW_CAP_V  = OUT_COLS_W'(OW_CAP);
   localparam logic [STEP_W-1:0]     LAST_STEP = STEP_W'(DIM_W - 1);

   front_state_type state_ff, state_in;

   logic [DIM_W-1:0]      in_width_ff, in_height_ff, out_height_ff;
   logic [OUT_COLS_W-1:0] out_width_ff;

   logic [DIM_W-1:0]      iw, ih;
   logic [OUT_COLS_W-1:0] ow;

   logic [STEP_W-1:0] step_ff;
   logic [DIM_W-1:0]  bw_ff, bh_ff, wr_ff, hr_ff;
   logic [DIM_W:0]    w_shift, h_shift;
   logic              w_fit, h_fit;
   logic [DIM_W-1:0]  w_rem, h_rem;

   logic [DIM_W-1:0]      col_ff, cw_ff, row_ff, rh_ff, br_ff;
   logic [OUT_COLS_W-1:0] bc_ff;

   logic csr_write, cfg_hit, div_load, div_step, accept;
   logic sizes_ok, in_block, first, last, done, col_wrap, row_wrap;
   logic [DIM_W-1:0] bw_last, bh_last;

   logic [AREA_W-1:0] area_ff;

   logic signed [SUM_W-1:0]    sums_mem [MEM_DEPTH];
   logic signed [SUM_W-1:0]    rd_ff;
   logic [IDX_W-1:0]           a_idx;
   logic                       b_valid_ff, b_first_ff, b_last_ff, b_done_ff;
   logic [IDX_W-1:0]           b_idx_ff;
   logic [COL_W-1:0]           b_col_ff;
   logic [ROW_W-1:0]           b_row_ff;
   logic signed [SAMPLE_W-1:0] b_sample_ff;
   logic                       fw_valid_ff;
   logic [IDX_W-1:0]           fw_idx_ff;
   logic signed [SUM_W-1:0]    fw_sum_ff;
   logic signed [SUM_W-1:0]    b_base, b_sum;

   // effective sizes
   assign iw = (in_width_ff > IW_CAP_V) ? IW_CAP_V : in_width_ff;
   assign ih = (in_height_ff > IH_CAP_V) ? IH_CAP_V : in_height_ff;
   assign ow = (out_width_ff > OW_CAP_V) ? OW_CAP_V : out_width_ff;

   assign csr_write = csr_chan.valid && csr_chan.ready;

   always_comb begin
      unique case (csr_chan.payload.index)
         REG_IN_WIDTH, REG_IN_HEIGHT, REG_OUT_WIDTH, REG_OUT_HEIGHT: cfg_hit = csr_write;
         default: cfg_hit = 1'b0;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         F_LOAD: state_in = F_RUN;
         F_RUN: begin
            if (step_ff == LAST_STEP) begin
               state_in = F_ACTIVE;
            end
         end
         F_ACTIVE: state_in = F_ACTIVE;
         default: state_in = F_LOAD;
      endcase
      if (cfg_hit) begin
         state_in = F_LOAD;
      end
   end

   always_comb begin
      csr_chan.ready = 1'b1;
      req_chan.ready = (state_ff == F_ACTIVE) && queue_room;
      div_load       = (state_ff == F_LOAD);
      div_step       = (state_ff == F_RUN);
   end

   assign accept = req_chan.valid && req_chan.ready;

   // block size division, one quotient bit a cycle
   assign w_shift = {wr_ff, bw_ff[DIM_W-1]};
   assign h_shift = {hr_ff, bh_ff[DIM_W-1]};
   assign w_fit   = w_shift >= (DIM_W + 1)'(ow);
   assign h_fit   = h_shift >= (DIM_W + 1)'(out_height_ff);
   assign w_rem   = w_fit ? DIM_W'(w_shift - (DIM_W + 1)'(ow)) : DIM_W'(w_shift);
   assign h_rem   = h_fit ? DIM_W'(h_shift - (DIM_W + 1)'(out_height_ff)) : DIM_W'(h_shift);

   // classification of the incoming sample
   assign bw_last  = bw_ff - DIM_W'(1);
   assign bh_last  = bh_ff - DIM_W'(1);
   assign sizes_ok = (ow != '0) && (out_height_ff != '0) && (bw_ff != '0) && (bh_ff != '0);
   assign in_block = sizes_ok && (bc_ff < ow) && (br_ff < out_height_ff);
   assign first    = (cw_ff == '0) && (rh_ff == '0);
   assign last     = (cw_ff == bw_last) && (rh_ff == bh_last);
   assign done     = (bc_ff == ow - OUT_COLS_W'(1)) && (br_ff == out_height_ff - DIM_W'(1));
   assign col_wrap = ({1'b0, col_ff} + (DIM_W + 1)'(1)) >= {1'b0, iw};
   assign row_wrap = ({1'b0, row_ff} + (DIM_W + 1)'(1)) >= {1'b0, ih};
   assign a_idx    = bc_ff[IDX_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_width_ff   <= RST_IN_WIDTH;
         in_height_ff  <= RST_IN_HEIGHT;
         out_width_ff  <= RST_OUT_WIDTH;
         out_height_ff <= RST_OUT_HEIGHT;
      end else if (csr_write) begin
         unique case (csr_chan.payload.index)
            REG_IN_WIDTH:   in_width_ff   <= csr_chan.payload.data;
            REG_IN_HEIGHT:  in_height_ff  <= csr_chan.payload.data;
            REG_OUT_WIDTH:  out_width_ff  <= csr_chan.payload.data[OUT_COLS_W-1:0];
            REG_OUT_HEIGHT: out_height_ff <= csr_chan.payload.data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (div_load) begin
         bw_ff   <= iw;
         bh_ff   <= ih;
         wr_ff   <= '0;
         hr_ff   <= '0;
         step_ff <= '0;
         col_ff  <= '0;
         cw_ff   <= '0;
         bc_ff   <= '0;
         row_ff  <= '0;
         rh_ff   <= '0;
         br_ff   <= '0;
      end else if (div_step) begin
         bw_ff   <= {bw_ff[DIM_W-2:0], w_fit};
         bh_ff   <= {bh_ff[DIM_W-2:0], h_fit};
         wr_ff   <= w_rem;
         hr_ff   <= h_rem;
         step_ff <= step_ff + STEP_W'(1);
      end else if (accept) begin
         if (col_wrap) begin
            col_ff <= '0;
            cw_ff  <= '0;
            bc_ff  <= '0;
            if (row_wrap) begin
               row_ff <= '0;
               rh_ff  <= '0;
               br_ff  <= '0;
            end else begin
               row_ff <= row_ff + DIM_W'(1);
               if (rh_ff == bh_last) begin
                  rh_ff <= '0;
                  if (br_ff < out_height_ff) begin
                     br_ff <= br_ff + DIM_W'(1);
                  end
               end else begin
                  rh_ff <= rh_ff + DIM_W'(1);
               end
            end
         end else begin
            col_ff <= col_ff + DIM_W'(1);
            if (cw_ff == bw_last) begin
               cw_ff <= '0;
               if (bc_ff < ow) begin
                  bc_ff <= bc_ff + OUT_COLS_W'(1);
               end
            end else begin
               cw_ff <= cw_ff + DIM_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      area_ff <= AREA_W'(bw_ff) * AREA_W'(bh_ff);
   end

   assign area = area_ff;

   // accumulator read-modify-write, previous write forwarded
   always_ff @(posedge clock) begin
      if (accept && in_block) begin
         rd_ff <= sums_mem[a_idx];
      end
      if (b_valid_ff) begin
         sums_mem[b_idx_ff] <= b_sum;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff  <= 1'b0;
         fw_valid_ff <= 1'b0;
      end else begin
         b_valid_ff  <= accept && in_block;
         fw_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      b_first_ff  <= first;
      b_last_ff   <= last;
      b_done_ff   <= done;
      b_idx_ff    <= a_idx;
      b_col_ff    <= bc_ff[COL_W-1:0];
      b_row_ff    <= br_ff[ROW_W-1:0];
      b_sample_ff <= req_chan.payload.sample;
      fw_idx_ff   <= b_idx_ff;
      fw_sum_ff   <= b_sum;
   end

   assign b_base = (fw_valid_ff && (fw_idx_ff == b_idx_ff)) ? fw_sum_ff : rd_ff;
   assign b_sum  = b_first_ff ? SUM_W'(b_sample_ff) : b_base + SUM_W'(b_sample_ff);

   assign push_valid     = b_valid_ff && b_last_ff;
   assign push_word.sum  = b_sum;
   assign push_word.col  = b_col_ff;
   assign push_word.row  = b_row_ff;
   assign push_word.done = b_done_ff;

   a_cfg_restarts: assert property (@(posedge clock) disable iff (reset)
      cfg_hit |=> !req_chan.ready)
      else $error("sample taken right after a register write");

   a_push_follows_accept: assert property (@(posedge clock) disable iff (reset)
      push_valid |-> $past(req_chan.valid && req_chan.ready))
      else $error("block word pushed without a sample the cycle before");

endmodule

/* hw/rtl/boxavg_queue.sv */
module boxavg_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push_valid,
   input  boxavg_pkg::block_word_type push_word,
   output logic                       queue_room,
   input  logic                       pop,
   output boxavg_pkg::queue_head_type head
);
   import boxavg_pkg::*;

   localparam logic [QCNT_W-1:0] ROOM_LIMIT = QCNT_W'(QUEUE_DEPTH - 2);
   localparam logic [QCNT_W-1:0] FULL_COUNT = QCNT_W'(QUEUE_DEPTH);

   block_word_type      entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0]   count_ff;

   // room for one word in flight plus the one being offered
   assign queue_room = count_ff <= ROOM_LIMIT;
   assign head.valid = count_ff != '0;
   assign head.word  = entries_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push_valid) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         end
         unique case ({push_valid, pop})
            2'b10:   count_ff <= count_ff + QCNT_W'(1);
            2'b01:   count_ff <= count_ff - QCNT_W'(1);
            default: count_ff <= count_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         entries_ff[wr_ptr_ff] <= push_word;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push_valid |-> (count_ff != FULL_COUNT) || pop)
      else $error("queue overflow");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> count_ff != '0)
      else $error("queue underflow");

endmodule

/* hw/rtl/boxavg_back.sv */
module boxavg_back (
   input  logic                          clock,
   input  logic                          reset,
   input  boxavg_pkg::queue_head_type    head,
   output logic                          pop,
   input  logic [boxavg_pkg::AREA_W-1:0] area,
   boxavg_stream_if.source               rsp_chan
);
   import boxavg_pkg::*;

   localparam int                 DIV_STEP_W    = $clog2(QUOT_W);
   localparam logic [DIV_STEP_W-1:0] LAST_DIV_STEP = DIV_STEP_W'(QUOT_W - 1);
   localparam logic [QUOT_W-1:0]  QUOT_MAX      = QUOT_W'(1) << (QUOT_W - 1);

   back_state_type state_ff, state_in;

   logic [SUM_W-1:0]      rem_ff, dsh_ff, mag;
   logic [QUOT_W-1:0]     quo_ff, avg_bits;
   logic [DIV_STEP_W-1:0] step_ff;
   logic                  neg_ff, done_ff;
   logic [COL_W-1:0]      col_ff;
   logic [ROW_W-1:0]      row_ff;
   logic                  out_valid_ff;
   rsp_word_type          out_word_ff;
   logic                  out_free, finish, fit;

   assign out_free = !out_valid_ff || rsp_chan.ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         B_IDLE: begin
            if (head.valid) begin
               state_in = B_RUN;
            end
         end
         B_RUN: begin
            if (step_ff == LAST_DIV_STEP) begin
               state_in = B_FINISH;
            end
         end
         B_FINISH: begin
            if (out_free) begin
               state_in = head.valid ? B_RUN : B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_comb begin
      finish = (state_ff == B_FINISH) && out_free;
      pop    = head.valid && ((state_ff == B_IDLE) || finish);
   end

   assign mag = head.word.sum[SUM_W-1] ? SUM_W'(-head.word.sum) : SUM_W'(head.word.sum);
   assign fit = rem_ff >= dsh_ff;
   assign avg_bits = neg_ff ? (QUOT_W'(0) - quo_ff) : quo_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (finish) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // magnitude restoring division, one quotient bit a cycle
   always_ff @(posedge clock) begin
      if (pop) begin
         rem_ff  <= mag;
         dsh_ff  <= SUM_W'(area) << (QUOT_W - 1);
         quo_ff  <= '0;
         step_ff <= '0;
         neg_ff  <= head.word.sum[SUM_W-1];
         col_ff  <= head.word.col;
         row_ff  <= head.word.row;
         done_ff <= head.word.done;
      end else if (state_ff == B_RUN) begin
         rem_ff  <= fit ? rem_ff - dsh_ff : rem_ff;
         dsh_ff  <= dsh_ff >> 1;
         quo_ff  <= {quo_ff[QUOT_W-2:0], fit};
         step_ff <= step_ff + DIV_STEP_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (finish) begin
         out_word_ff.average  <= $signed(avg_bits);
         out_word_ff.out_col  <= col_ff;
         out_word_ff.out_row  <= row_ff;
         out_word_ff.map_done <= done_ff;
      end
   end

   assign rsp_chan.valid   = out_valid_ff;
   assign rsp_chan.payload = out_word_ff;

   a_mean_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == B_FINISH |-> (quo_ff <= QUOT_MAX) && (neg_ff || (quo_ff != QUOT_MAX)))
      else $error("block mean outside sample range");

   a_word_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_chan.valid) |-> $past(state_ff == B_FINISH))
      else $error("result word raised outside the finishing cycle");

endmodule

/* hw/rtl/box_average_downsampler.sv */
// channel    dir  word
// csr_chan   in   index, data (register write)
// req_chan   in   sample
// rsp_chan   out  average, out_col, out_row, map_done
//
// the front takes one sample a cycle when ready; done blocks queue (four deep) for the back
// the back divider handles one block at a time, one quotient bit a cycle
// block ends arriving faster than means finish fill the queue and drop req_chan.ready
// reset (synchronous) and every size register write start a block size division,
// req_chan.ready low meanwhile
// a stalled rsp_chan holds its word and the divider finishes the next mean behind it
module box_average_downsampler #(
   parameter int MAX_IN_WIDTH  = 1024,
   parameter int MAX_IN_HEIGHT = 1024,
   parameter int MAX_OUT_COLS  = 256
) (
   input  logic            clock,
   input  logic            reset,
   boxavg_stream_if.sink   csr_chan,
   boxavg_stream_if.sink   req_chan,
   boxavg_stream_if.source rsp_chan
);
   import boxavg_pkg::*;

   logic              push_valid;
   block_word_type    push_word;
   logic              queue_room;
   logic              pop;
   queue_head_type    head;
   logic [AREA_W-1:0] area;

   boxavg_front #(
      .MAX_IN_WIDTH  (MAX_IN_WIDTH),
      .MAX_IN_HEIGHT (MAX_IN_HEIGHT),
      .MAX_OUT_COLS  (MAX_OUT_COLS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_chan   (csr_chan),
      .req_chan   (req_chan),
      .queue_room (queue_room),
      .push_valid (push_valid),
      .push_word  (push_word),
      .area       (area)
   );

   boxavg_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_word  (push_word),
      .queue_room (queue_room),
      .pop        (pop),
      .head       (head)
   );

   boxavg_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .pop      (pop),
      .area     (area),
      .rsp_chan (rsp_chan)
   );

endmodule

/* bench/tb_top.sv */
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import boxavg_pkg::*;

   localparam int MAX_IN_WIDTH  = 1024;
   localparam int MAX_IN_HEIGHT = 1024;
   localparam int MAX_OUT_COLS  = 256;
   localparam int REG_COUNT     = 4;
   localparam int RANDOM_ITEMS  = 920;
   localparam int SETTLE_CYCLES = 120;
   localparam int HOLD_CYCLES   = 400;
   localparam int CYCLE_LIMIT   = 1000000;
   localparam int MAX_REPORTS   = 40;

   localparam logic [CSR_IDX_W-1:0] REG_SPARE_FIRST = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_LAST  = 3'd7;

   typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idling_type;
   typedef enum int {STYLE_RAIL, STYLE_SMALL, STYLE_FULL} sample_style_type;

   class downsample_scoreboard;
      logic [DIM_W-1:0]      in_width;
      logic [DIM_W-1:0]      in_height;
      logic [OUT_COLS_W-1:0] out_width;
      logic [DIM_W-1:0]      out_height;
      longint                block_sum [MAX_OUT_COLS];
      int unsigned           in_col;
      int unsigned           in_row;
      int unsigned           blk_w;
      int unsigned           blk_h;
      rsp_word_type          mean_q [$];
      int                    mismatches;

      function int unsigned span_w();
         return (in_width > MAX_IN_WIDTH) ? MAX_IN_WIDTH : in_width;
      endfunction

      function int unsigned span_h();
         return (in_height > MAX_IN_HEIGHT) ? MAX_IN_HEIGHT : in_height;
      endfunction

      function int unsigned cols_out();
         return (out_width > MAX_OUT_COLS) ? MAX_OUT_COLS : out_width;
      endfunction

      function void rederive();
         blk_w  = (cols_out() != 0) ? span_w() / cols_out() : 0;
         blk_h  = (out_height != 0) ? span_h() / out_height : 0;
         in_col = 0;
         in_row = 0;
      endfunction

      function void clear();
         in_width   = RST_IN_WIDTH;
         in_height  = RST_IN_HEIGHT;
         out_width  = RST_OUT_WIDTH;
         out_height = RST_OUT_HEIGHT;
         foreach (block_sum[i]) block_sum[i] = 0;
         mismatches = 0;
         rederive();
      endfunction

      function void write_register(logic [CSR_IDX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
         case (index)
            REG_IN_WIDTH:   in_width   = data;
            REG_IN_HEIGHT:  in_height  = data;
            REG_OUT_WIDTH:  out_width  = data[OUT_COLS_W-1:0];
            REG_OUT_HEIGHT: out_height = data;
            default: return;
         endcase
         rederive();
      endfunction

      function int pending();
         return mean_q.size();
      endfunction

      function void note_sample(logic signed [SAMPLE_W-1:0] sample);
         int unsigned  bc;
         int unsigned  br;
         int unsigned  ow;
         int unsigned  oh;
         longint       mean;
         rsp_word_type word;
         ow = cols_out();
         oh = 32'(out_height);
         if (blk_w != 0 && blk_h != 0 && in_col < blk_w * ow && in_row < blk_h * oh) begin
            bc = in_col / blk_w;
            br = in_row / blk_h;
            if (in_col % blk_w == 0 && in_row % blk_h == 0)
               block_sum[bc] = longint'(sample);
            else
               block_sum[bc] += longint'(sample);
            if (in_col % blk_w == blk_w - 1 && in_row % blk_h == blk_h - 1) begin
               mean          = block_sum[bc] / (longint'(blk_w) * longint'(blk_h));
               word.average  = mean[SAMPLE_W-1:0];
               word.out_col  = bc[COL_W-1:0];
               word.out_row  = br[ROW_W-1:0];
               word.map_done = (bc == ow - 1 && br == oh - 1);
               mean_q = {mean_q, word};
            end
         end
         in_col++;
         if (in_col >= span_w()) begin
            in_col = 0;
            in_row++;
            if (in_row >= span_h())
               in_row = 0;
         end
      endfunction

      task report_mismatch(string what);
         mismatches++;
         if (mismatches <= MAX_REPORTS)
            $display("mismatch %0d at %0t: %s", mismatches, $realtime, what);
      endtask

      task check_mean(rsp_word_type got);
         rsp_word_type want;
         if (mean_q.size() == 0) begin
            report_mismatch($sformatf("unexpected word avg %0d col %0d row %0d done %0b",
                                      got.average, got.out_col, got.out_row, got.map_done));
            return;
         end
         want = mean_q.pop_front();
         if (got.average !== want.average)
            report_mismatch($sformatf("average %0d, want %0d (col %0d row %0d)",
                                      got.average, want.average, want.out_col, want.out_row));
         if (got.out_col !== want.out_col)
            report_mismatch($sformatf("out_col %0d, want %0d", got.out_col, want.out_col));
         if (got.out_row !== want.out_row)
            report_mismatch($sformatf("out_row %0d, want %0d", got.out_row, want.out_row));
         if (got.map_done !== want.map_done)
            report_mismatch($sformatf("map_done %0b, want %0b (col %0d row %0d)",
                                      got.map_done, want.map_done, want.out_col, want.out_row));
      endtask
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   boxavg_stream_if #(.word_type(csr_word_type)) csr_chan ();
   boxavg_stream_if #(.word_type(req_word_type)) req_chan ();
   boxavg_stream_if #(.word_type(rsp_word_type)) rsp_chan ();

   box_average_downsampler u_top (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   downsample_scoreboard sb = new;

   int          send_idle_pct  = 0;
   int          recv_stall_pct = 0;
   int          hold_asks      = 0;
   int          hold_seen      = 0;
   int          hold_left      = 0;
   int unsigned cycles         = 0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("box_average_downsampler test failed");
         $finish;
      end
   end

   // result side: check accepted words, then choose next ready
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1)
         sb.check_mean(rsp_chan.payload);
      if (hold_asks != hold_seen) begin
         hold_seen = hold_asks;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= ($urandom_range(99, 0) >= recv_stall_pct);
      end
   end

   task set_idling(idling_type mode);
      case (mode)
         IDLE_NONE: begin
            send_idle_pct  = 0;
            recv_stall_pct = 0;
         end
         IDLE_SENDER: begin
            send_idle_pct  = 63;
            recv_stall_pct = 0;
         end
         IDLE_RECEIVER: begin
            send_idle_pct  = 0;
            recv_stall_pct = 63;
         end
         default: begin
            send_idle_pct  = 38;
            recv_stall_pct = 38;
         end
      endcase
   endtask

   task write_register(logic [CSR_IDX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
      csr_chan.valid   <= 1'b1;
      csr_chan.payload <= '{index: index, data: data};
      @(posedge clock);
      while (csr_chan.ready !== 1'b1) @(posedge clock);
      sb.write_register(index, data);
   endtask

   // all four registers in a rotated order, now and then a spare index as well
   task apply_geometry(logic [CSR_DATA_W-1:0] iw, logic [CSR_DATA_W-1:0] ih,
                       logic [CSR_DATA_W-1:0] ow, logic [CSR_DATA_W-1:0] oh);
      logic [CSR_DATA_W-1:0] vals [2**CSR_IDX_W];
      int                    first;
      logic [CSR_IDX_W-1:0]  index;
      vals[REG_IN_WIDTH]   = iw;
      vals[REG_IN_HEIGHT]  = ih;
      vals[REG_OUT_WIDTH]  = ow;
      vals[REG_OUT_HEIGHT] = oh;
      first = $urandom_range(REG_COUNT - 1, 0);
      if ($urandom_range(3, 0) == 0)
         write_register(CSR_IDX_W'($urandom_range(REG_SPARE_LAST, REG_SPARE_FIRST)),
                        CSR_DATA_W'($urandom()));
      for (int k = 0; k < REG_COUNT; k++) begin
         index = CSR_IDX_W'((first + k) % REG_COUNT);
         write_register(index, vals[index]);
      end
      csr_chan.valid <= 1'b0;
   endtask

   task push_sample(logic signed [SAMPLE_W-1:0] sample);
      while ($urandom_range(99, 0) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.payload <= '{sample: sample};
      @(posedge clock);
      while (req_chan.ready !== 1'b1) @(posedge clock);
      sb.note_sample(sample);
   endtask

   function logic signed [SAMPLE_W-1:0] gen_sample(sample_style_type style);
      case (style)
         STYLE_RAIL:  return $urandom_range(1, 0) ? 16'sh7FFF : 16'sh8000;
         STYLE_SMALL: return SAMPLE_W'(int'($urandom_range(8, 0)) - 4);
         default:     return SAMPLE_W'($urandom());
      endcase
   endfunction

   task run_samples(int count, sample_style_type style);
      for (int i = 0; i < count; i++)
         push_sample(gen_sample(style));
   endtask

   // lowers the word offer, waits for every mean, then optionally lets the pipe settle
   task pause_sender(bit settle);
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      if (settle)
         repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task run_random_phase(idling_type mode, output int sent);
      int                    kind;
      logic [CSR_DATA_W-1:0] iw;
      logic [CSR_DATA_W-1:0] ih;
      logic [CSR_DATA_W-1:0] ow;
      logic [CSR_DATA_W-1:0] oh;
      kind = $urandom_range(9, 0);
      if (kind == 0) begin
         // mostly zero-sized blocks, zero input sizes too
         iw   = CSR_DATA_W'($urandom_range(12, 0));
         ih   = CSR_DATA_W'($urandom_range(12, 0));
         ow   = CSR_DATA_W'($urandom());
         oh   = ($urandom_range(1, 0) != 0) ? CSR_DATA_W'($urandom()) : '0;
         sent = 12;
      end else begin
         if (kind == 9) begin
            iw = CSR_DATA_W'($urandom_range(40, 9));
            ih = CSR_DATA_W'($urandom_range(4, 1));
         end else begin
            iw = CSR_DATA_W'($urandom_range(8, 1));
            ih = CSR_DATA_W'($urandom_range(8, 1));
         end
         ow   = CSR_DATA_W'($urandom_range(iw, 1));
         oh   = CSR_DATA_W'($urandom_range(ih, 1));
         ow   = ow | (CSR_DATA_W'($urandom_range(3, 0)) << OUT_COLS_W);
         sent = int'(iw * ih * $urandom_range(2, 1) + $urandom_range(iw, 0));
      end
      pause_sender(1'b1);
      set_idling(mode);
      apply_geometry(iw, ih, ow, oh);
      run_samples(sent, sample_style_type'($urandom_range(STYLE_FULL, STYLE_RAIL)));
   endtask

   logic signed [SAMPLE_W-1:0] corner_map [16] = '{
      16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000,
      16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000,
      -16'sd1,   -16'sd1,   16'sd3,    16'sd3,
      -16'sd1,   16'sd0,    16'sd3,    -16'sd2
   };

   initial begin
      int sent;
      int total;
      int phase;
      csr_chan.valid   = 1'b0;
      csr_chan.payload = '0;
      req_chan.valid   = 1'b0;
      req_chan.payload = '0;
      sb.clear();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // reset geometry, far from any block end
      set_idling(IDLE_NONE);
      run_samples(4, STYLE_FULL);
      pause_sender(1'b1);

      // 2x2 blocks: rails, truncation toward zero
      apply_geometry(11'd4, 11'd4, 11'd2, 11'd2);
      foreach (corner_map[i]) push_sample(corner_map[i]);
      pause_sender(1'b1);

      // more output columns than input columns, then zero input width
      apply_geometry(11'd4, 11'd4, 11'd5, 11'd2);
      push_sample(16'sh8000);
      push_sample(16'sh7FFF);
      push_sample(16'sd0);
      pause_sender(1'b1);
      apply_geometry(11'd0, 11'd3, 11'd1, 11'd1);
      run_samples(3, STYLE_FULL);
      pause_sender(1'b1);

      // spare register index must leave the raster position alone
      apply_geometry(11'd2, 11'd2, 11'd2, 11'd2);
      run_samples(2, STYLE_FULL);
      pause_sender(1'b1);
      write_register(REG_SPARE_FIRST, CSR_DATA_W'($urandom()));
      csr_chan.valid <= 1'b0;
      run_samples(2, STYLE_FULL);

      // long receiver hold-off with one mean per word, then a full drain mid-map
      pause_sender(1'b1);
      apply_geometry(11'd8, 11'd8, 11'd8, 11'd8);
      hold_asks++;
      run_samples(40, STYLE_FULL);
      pause_sender(1'b0);
      run_samples(24, STYLE_FULL);

      // oversized width and too many output columns
      pause_sender(1'b1);
      set_idling(IDLE_SENDER);
      apply_geometry(11'd2047, 11'd1, 11'd300, 11'd1);
      run_samples(64, STYLE_FULL);

      // oversized height
      pause_sender(1'b1);
      set_idling(IDLE_RECEIVER);
      apply_geometry(11'd1, 11'd2047, 11'd1, 11'd300);
      run_samples(64, STYLE_FULL);

      total = 0;
      phase = 0;
      while (total < RANDOM_ITEMS) begin
         run_random_phase(idling_type'(phase % 4), sent);
         total += sent;
         phase++;
      end

      pause_sender(1'b1);
      if (sb.mismatches == 0 && sb.pending() == 0)
         $display("box_average_downsampler test passed");
      else
         $display("box_average_downsampler test failed");
      $finish;
   end

endmodule

/* box_average_downsampler.f */
hw/rtl/boxavg_pkg.sv
hw/rtl/boxavg_stream_if.sv
hw/rtl/boxavg_front.sv
hw/rtl/boxavg_queue.sv
hw/rtl/boxavg_back.sv
hw/rtl/box_average_downsampler.sv
bench/tb_top.sv
